[src/sal_pkg.sv]
package sal_pkg;

  localparam int CAPACITY_DEF = 128;
  localparam int WORD_W       = 32;
  localparam int IDX_W        = 13;
  localparam int FAN_IN       = 16;
  localparam int PICK_W       = WORD_W + 1;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_POP_FRONT  = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_FIND       = 3'd4,
    OP_ERASE      = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic              load;
    logic              shift_up;
    logic              shift_dn;
    logic              wr;
    logic              rd;
    logic              find;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  cnt;
    logic [WORD_W-1:0] word;
  } cell_ctl_t;

  // entries left after k reduction levels
  function automatic int lvl_width(input int cap, input int k);
    int w;
    w = cap;
    for (int i = 0; i < k; i++) begin
      w = (w + FAN_IN - 1) / FAN_IN;
    end
    return w;
  endfunction

  function automatic int tree_levels(input int cap);
    int w;
    int l;
    w = cap;
    l = 0;
    while (w > 1) begin
      w = (w + FAN_IN - 1) / FAN_IN;
      l++;
    end
    return l;
  endfunction

endpackage

[src/sal_cell.sv]
module sal_cell #(
  parameter int IDX = 0
) (
  input  logic                           clk,
  input  sal_pkg::cell_ctl_t             ctl,
  input  logic [sal_pkg::WORD_W-1:0]     left_data,
  input  logic [sal_pkg::WORD_W-1:0]     right_data,
  output logic [sal_pkg::WORD_W-1:0]     data,
  output logic [sal_pkg::PICK_W-1:0]     pick
);

  localparam logic [sal_pkg::IDX_W-1:0] MY_IDX = sal_pkg::IDX_W'(IDX);

  logic [sal_pkg::WORD_W-1:0] data_r, data_nxt;
  logic [sal_pkg::PICK_W-1:0] pick_r, pick_nxt;

  always_comb begin
    priority if (ctl.shift_up) begin
      data_nxt = left_data;
    end else if (ctl.shift_dn && (MY_IDX >= ctl.idx)) begin
      data_nxt = right_data;
    end else if (ctl.wr && (MY_IDX == ctl.idx)) begin
      data_nxt = ctl.word;
    end else begin
      data_nxt = data_r;
    end
  end

  always_comb begin
    priority if (!ctl.load) begin
      pick_nxt = pick_r;
    end else if (ctl.rd && (MY_IDX == ctl.idx)) begin
      pick_nxt = {1'b0, data_r};
    end else if (ctl.find && (MY_IDX < ctl.cnt) && (data_r == ctl.word)) begin
      pick_nxt = {1'b1, data_r};
    end else begin
      pick_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    pick_r <= pick_nxt;
  end

  assign data = data_r;
  assign pick = pick_r;

endmodule

[src/sal_or_stage.sv]
module sal_or_stage #(
  parameter int N_IN  = 16,
  parameter int N_OUT = 1
) (
  input  logic                                   clk,
  input  logic [N_IN-1:0][sal_pkg::PICK_W-1:0]   din,
  output logic [N_OUT-1:0][sal_pkg::PICK_W-1:0]  dout
);

  logic [N_OUT-1:0][sal_pkg::PICK_W-1:0] dout_r, dout_nxt;

  always_comb begin
    for (int j = 0; j < N_OUT; j++) begin
      dout_nxt[j] = '0;
      for (int i = 0; i < sal_pkg::FAN_IN; i++) begin
        if (j * sal_pkg::FAN_IN + i < N_IN) begin
          dout_nxt[j] = dout_nxt[j] | din[j * sal_pkg::FAN_IN + i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    dout_r <= dout_nxt;
  end

  assign dout = dout_r;

endmodule

[src/shift_array_list_engine.sv]
// Ordered list of up to CAPACITY signed 32-bit words held in a row of cells, front at
// cell 0. Each input word carries one operation (push/pop at either end, find, erase at
// a position) and yields exactly one result word with the read value, found flag,
// status and the count after the operation. Push-front, pop-front and erase shift cells
// at once in the accept cycle; read values and find hits are collected by a registered
// OR tree of fan-in 16 fed by the cell pick registers, and the result goes into the
// output register once it is free. One operation is in flight at a time; the next is
// taken while the previous result still waits in the output register.
module shift_array_list_engine #(
  parameter int CAPACITY = sal_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // data_word[31:0], position[38:32], zero pad
  input  logic [2:0]  in_tuser,   // opcode[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // read_value[31:0], count[39:32]
  output logic [2:0]  out_tuser   // found[0], status[2:1]
);

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int LEVELS = sal_pkg::tree_levels(CAPACITY);
  localparam int LCW    = $clog2(LEVELS + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  sal_pkg::state_t state_r, state_nxt;
  logic [LCW-1:0]  scan_cnt_r, scan_cnt_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [1:0]      res_status_r, res_status_nxt;
  logic [7:0]      res_count_r;
  logic            res_find_r;
  logic            out_valid_r, out_valid_nxt;
  logic [39:0]     out_data_r;
  logic [2:0]      out_user_r;

  logic            accept;
  logic            load_out;
  sal_pkg::cell_ctl_t ctl;
  logic [sal_pkg::WORD_W-1:0] word_in;
  logic [6:0]      pos_in;
  logic [sal_pkg::IDX_W-1:0] cnt_x, pos_x;

  logic [CAPACITY-1:0][sal_pkg::WORD_W-1:0] cell_data;
  logic [CAPACITY-1:0][sal_pkg::PICK_W-1:0] tree [LEVELS+1];
  logic [sal_pkg::PICK_W-1:0] root;

  assign word_in = in_tdata[31:0];
  assign pos_in  = in_tdata[38:32];
  assign cnt_x   = sal_pkg::IDX_W'(count_r);
  assign pos_x   = sal_pkg::IDX_W'(pos_in);
  assign accept  = in_tvalid && in_tready;

  // operation decode
  always_comb begin
    ctl            = '0;
    ctl.load       = accept;
    ctl.word       = word_in;
    ctl.cnt        = cnt_x;
    count_nxt      = count_r;
    res_status_nxt = sal_pkg::ST_OK;
    if (accept) begin
      unique case (sal_pkg::op_t'(in_tuser))
        sal_pkg::OP_PUSH_FRONT, sal_pkg::OP_PUSH_BACK: begin
          if (count_r >= CAP_C) begin
            res_status_nxt = sal_pkg::ST_FULL;
          end else begin
            ctl.shift_up = (sal_pkg::op_t'(in_tuser) == sal_pkg::OP_PUSH_FRONT);
            ctl.wr       = (sal_pkg::op_t'(in_tuser) == sal_pkg::OP_PUSH_BACK);
            ctl.idx      = cnt_x;
            count_nxt    = count_r + CW'(1);
          end
        end
        sal_pkg::OP_POP_FRONT: begin
          if (count_r == '0) begin
            res_status_nxt = sal_pkg::ST_EMPTY;
          end else begin
            ctl.rd       = 1'b1;
            ctl.shift_dn = 1'b1;
            ctl.idx      = '0;
            count_nxt    = count_r - CW'(1);
          end
        end
        sal_pkg::OP_POP_BACK: begin
          if (count_r == '0) begin
            res_status_nxt = sal_pkg::ST_EMPTY;
          end else begin
            ctl.rd    = 1'b1;
            ctl.idx   = cnt_x - sal_pkg::IDX_W'(1);
            count_nxt = count_r - CW'(1);
          end
        end
        sal_pkg::OP_FIND: begin
          if (count_r == '0) begin
            res_status_nxt = sal_pkg::ST_EMPTY;
          end else begin
            ctl.find = 1'b1;
          end
        end
        sal_pkg::OP_ERASE: begin
          if (count_r == '0) begin
            res_status_nxt = sal_pkg::ST_EMPTY;
          end else if (pos_x >= cnt_x) begin
            res_status_nxt = sal_pkg::ST_RANGE;
          end else begin
            ctl.shift_dn = 1'b1;
            ctl.idx      = pos_x;
            count_nxt    = count_r - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [sal_pkg::WORD_W-1:0] left_d, right_d;
      if (gi == 0) begin : g_first
        assign left_d = word_in;
      end else begin : g_mid_l
        assign left_d = cell_data[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_d = cell_data[gi];
      end else begin : g_mid_r
        assign right_d = cell_data[gi+1];
      end
      sal_cell #(.IDX(gi)) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .left_data  (left_d),
        .right_data (right_d),
        .data       (cell_data[gi]),
        .pick       (tree[0][gi])
      );
    end

    for (gi = 1; gi <= LEVELS; gi++) begin : g_lvl
      localparam int WI = sal_pkg::lvl_width(CAPACITY, gi - 1);
      localparam int WO = sal_pkg::lvl_width(CAPACITY, gi);
      sal_or_stage #(.N_IN(WI), .N_OUT(WO)) u_stage (
        .clk  (clk),
        .din  (tree[gi-1][WI-1:0]),
        .dout (tree[gi][WO-1:0])
      );
      if (WO < CAPACITY) begin : g_tie
        assign tree[gi][CAPACITY-1:WO] = '0;
      end
    end
  endgenerate

  assign root = tree[LEVELS][0];

  // next state
  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    unique case (state_r)
      sal_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt    = sal_pkg::S_SCAN;
          scan_cnt_nxt = '0;
        end
      end
      sal_pkg::S_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + LCW'(1);
        if (scan_cnt_r == LCW'(LEVELS - 1)) begin
          state_nxt = sal_pkg::S_LOAD;
        end
      end
      sal_pkg::S_LOAD: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = sal_pkg::S_IDLE;
        end
      end
      default: state_nxt = sal_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      sal_pkg::S_IDLE: in_tready = 1'b1;
      sal_pkg::S_SCAN: begin
      end
      sal_pkg::S_LOAD: load_out = !out_valid_r || out_tready;
      default: begin
      end
    endcase
  end

  always_comb begin
    priority if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sal_pkg::S_IDLE;
      scan_cnt_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_status_r <= res_status_nxt;
      res_count_r  <= 8'(count_nxt);
      res_find_r   <= ctl.find;
    end
    if (load_out) begin
      out_data_r <= {res_count_r, root[sal_pkg::WORD_W-1:0]};
      out_user_r <= {res_status_r, root[sal_pkg::WORD_W] & res_find_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

[src/sal_checker.sv]
module sal_checker #(
  parameter int CAPACITY = sal_pkg::CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [39:0] in_tdata,
  input logic [2:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [2:0]  out_tuser
);

  localparam logic [7:0] CAP_LO = 8'(CAPACITY);

  // one operation in flight
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word accepted while busy");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[2:1] == sal_pkg::ST_OK)
    else $error("found with bad status");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:1] == sal_pkg::ST_EMPTY
      |-> out_tdata[31:0] == 32'd0 && !out_tuser[0] && out_tdata[39:32] == 8'd0)
    else $error("empty result carries data");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:1] == sal_pkg::ST_FULL |-> out_tdata[39:32] == CAP_LO)
    else $error("full status with wrong count");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready
      |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind shift_array_list_engine sal_checker #(.CAPACITY(CAPACITY)) u_sal_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
